// ===== design/smf_pkg.sv =====
// Shared types, constants and helpers for the substring match finder.
`default_nettype none
package smf_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 65536;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 64;
    localparam int PAT_W    = 2 * WORD_W;
    localparam int LEN_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int POS_W    = 16;
    localparam int INDEX_W  = 17;
    localparam int TALLY_W  = 16;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    localparam int CFG_IDX_W = 2;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 2'd3;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic [POS_W-1:0]   match_start;
        logic [TALLY_W-1:0] total_matches;
        logic               overflowed;
        logic               run_last;
    } result_t;

    // Up to two results enter the output queue per beat, in order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } smf_push_t;

    // Length in use: zero reads as one, above max reads as max
    function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
            r = LEN_W'(1);
        else if (len > LEN_W'(MAX_PATTERN))
            r = LEN_W'(MAX_PATTERN);
        return r;
    endfunction

    // Pattern byte expected at window slot j (slot 0 holds the newest byte)
    function automatic logic [BYTE_W-1:0] expect_byte(input logic [PAT_W-1:0]  pat,
                                                      input logic [LEN_W-1:0]  len,
                                                      input logic [LEN_W-1:0]  slot);
        logic [LEN_W-1:0]  diff;
        logic [SLOT_W-1:0] idx;
        diff = len - LEN_W'(1) - slot;
        idx  = diff[SLOT_W-1:0];
        return pat[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage
`default_nettype wire

// ===== design/substring_match_finder_unit.sv =====
// Top level of the substring match finder: window cell chain, match logic, result queue.
`default_nettype none
// Streams a text one byte per beat and reports the start index of each
// occurrence of a 1..16 byte pattern. A row of 16 cells holds the newest
// bytes; every cell compares its incoming byte against the pattern byte
// aligned to it, so a full match decision is made in the cycle the byte is
// taken. One text byte is accepted per cycle while the result queue has
// room. Results pass through a four-entry queue that drains one result a
// cycle while result_ready is high; a byte that both ends a text and
// completes a match yields two results (match first, then summary), so
// result_ready and that queue set the sustained rate, which is one byte a
// cycle while results are taken as offered. After an end-of-text byte all
// scan state returns to reset while the configuration is kept. Config
// writes (index 0/1 pattern bytes low/high, 2 pattern length, 3 overlap
// mode) are always ready and are meant to be issued only while the block
// is idle. Position and match count saturate and set the overflowed flag.
module substring_match_finder_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // text beats
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire smf_pkg::item_t                    item,
    // result beats
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output smf_pkg::result_t                       result,
    // config writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [smf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smf_pkg::WORD_W-1:0]        cfg_data
);

    // config registers
    logic [smf_pkg::WORD_W-1:0]  pat_lo_reg;
    logic [smf_pkg::WORD_W-1:0]  pat_hi_reg;
    logic [smf_pkg::LEN_W-1:0]   len_reg;
    logic                        overlap_reg;

    // scan state
    logic [smf_pkg::LEN_W-1:0]   filled_reg, filled_next;
    logic [smf_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [smf_pkg::LEN_W-1:0]   since_reg, since_next;
    logic [smf_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic                        ovf_reg, ovf_next;

    logic                        take;
    logic                        room;
    logic [smf_pkg::LEN_W-1:0]   len_use;
    logic [smf_pkg::PAT_W-1:0]   pattern;
    logic                        at_max;
    logic [smf_pkg::POS_W-1:0]   pos;
    logic [smf_pkg::INDEX_W-1:0] pos_plus;
    logic [smf_pkg::INDEX_W-1:0] start_wide;
    logic [smf_pkg::LEN_W-1:0]   filled_inc;
    logic [smf_pkg::LEN_W-1:0]   since_inc;
    logic                        all_agree;
    logic                        hit;
    logic                        tally_full;
    logic [smf_pkg::TALLY_W-1:0] tally_upd;
    logic                        ovf_upd;
    smf_pkg::smf_push_t          push;
    smf_pkg::result_t            match_res;
    smf_pkg::result_t            sum_res;

    logic [smf_pkg::BYTE_W-1:0]  win [smf_pkg::MAX_PATTERN];
    logic [smf_pkg::MAX_PATTERN-1:0] agree;

    assign cfg_ready  = 1'b1;
    assign item_ready = room;
    assign take       = item_valid && item_ready;
    assign len_use    = smf_pkg::used_length(len_reg);
    assign pattern    = {pat_hi_reg, pat_lo_reg};

    // window chain: cell 0 takes the new byte, each cell feeds the next
    for (genvar j = 0; j < smf_pkg::MAX_PATTERN; j++)
    begin : g_cell
        logic [smf_pkg::BYTE_W-1:0] feed;
        logic [smf_pkg::BYTE_W-1:0] exp_b;
        logic                       used;

        if (j == 0)
        begin : g_head
            assign feed = item.text_byte;
        end
        else
        begin : g_body
            assign feed = win[j-1];
        end

        assign exp_b = smf_pkg::expect_byte(pattern, len_use, smf_pkg::LEN_W'(j));
        assign used  = (smf_pkg::LEN_W'(j) < len_use);

        smf_cell u_cell (
            .clk      (clk),
            .shift    (take),
            .byte_in  (feed),
            .pat_byte (exp_b),
            .used     (used),
            .byte_out (win[j]),
            .agree    (agree[j])
        );
    end

    assign all_agree = &agree;

    // per-byte decision
    always_comb
    begin
        at_max     = index_reg[smf_pkg::INDEX_W-1];
        pos        = at_max ? '1 : index_reg[smf_pkg::POS_W-1:0];
        filled_inc = (filled_reg < smf_pkg::LEN_W'(smf_pkg::MAX_PATTERN))
                     ? smf_pkg::LEN_W'(filled_reg + 1'b1) : filled_reg;
        since_inc  = (since_reg < smf_pkg::LEN_W'(smf_pkg::MAX_PATTERN))
                     ? smf_pkg::LEN_W'(since_reg + 1'b1) : since_reg;

        hit = (filled_inc >= len_use) && all_agree
              && (overlap_reg || (since_inc >= len_use));

        // start = pos + 1 - len, floored at zero; never above the field
        pos_plus   = smf_pkg::INDEX_W'({1'b0, pos}) + smf_pkg::INDEX_W'(1);
        start_wide = (pos_plus >= smf_pkg::INDEX_W'(len_use))
                     ? smf_pkg::INDEX_W'(pos_plus - smf_pkg::INDEX_W'(len_use))
                     : '0;

        tally_full = (tally_reg == '1);
        tally_upd  = (hit && !tally_full) ? smf_pkg::TALLY_W'(tally_reg + 1'b1) : tally_reg;
        ovf_upd    = ovf_reg || at_max || (hit && tally_full);

        match_res.result_kind   = smf_pkg::KIND_MATCH;
        match_res.match_start   = start_wide[smf_pkg::POS_W-1:0];
        match_res.total_matches = tally_upd;
        match_res.overflowed    = ovf_upd;
        match_res.run_last      = !item.end_of_text;

        sum_res.result_kind     = smf_pkg::KIND_SUMMARY;
        sum_res.match_start     = '0;
        sum_res.total_matches   = tally_upd;
        sum_res.overflowed      = ovf_upd;
        sum_res.run_last        = 1'b1;

        push.cnt    = 2'd0;
        push.first  = hit ? match_res : sum_res;
        push.second = sum_res;
        if (take)
        begin
            push.cnt = {1'b0, hit} + {1'b0, item.end_of_text};
        end

        filled_next = filled_reg;
        index_next  = index_reg;
        since_next  = since_reg;
        tally_next  = tally_reg;
        ovf_next    = ovf_reg;
        if (take)
        begin
            if (item.end_of_text)
            begin
                filled_next = '0;
                index_next  = '0;
                since_next  = smf_pkg::LEN_W'(smf_pkg::MAX_PATTERN);
                tally_next  = '0;
                ovf_next    = 1'b0;
            end
            else
            begin
                filled_next = filled_inc;
                index_next  = at_max ? index_reg : smf_pkg::INDEX_W'(index_reg + 1'b1);
                since_next  = hit ? '0 : since_inc;
                tally_next  = tally_upd;
                ovf_next    = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            index_reg  <= '0;
            since_reg  <= smf_pkg::LEN_W'(smf_pkg::MAX_PATTERN);
            tally_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            index_reg  <= index_next;
            since_reg  <= since_next;
            tally_reg  <= tally_next;
            ovf_reg    <= ovf_next;
        end
    end

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            len_reg     <= smf_pkg::LEN_W'(1);
            overlap_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                smf_pkg::REG_PAT_LO:  pat_lo_reg  <= cfg_data;
                smf_pkg::REG_PAT_HI:  pat_hi_reg  <= cfg_data;
                smf_pkg::REG_PAT_LEN: len_reg     <= cfg_data[smf_pkg::LEN_W-1:0];
                smf_pkg::REG_OVERLAP: overlap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    smf_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // end of text clears the scan state
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.end_of_text) |=>
            (filled_reg == '0 && index_reg == '0 && tally_reg == '0 && !ovf_reg))
        else $error("scan state not cleared after end of text");

    // position counter stops at MAX_TEXT
    a_index_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !(index_reg[smf_pkg::INDEX_W-1] && index_reg[smf_pkg::POS_W-1:0] != '0))
        else $error("text index past saturation");

    // fill count bounded by the window depth
    a_filled_max: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= smf_pkg::LEN_W'(smf_pkg::MAX_PATTERN))
        else $error("fill count above window depth");

    // tally only moves on an accepted byte
    a_tally_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_valid && item_ready) |=> $stable(tally_reg))
        else $error("match tally changed without a text beat");
`endif

endmodule
`default_nettype wire

// ===== design/smf_cell.sv =====
// One window cell: holds one text byte and compares the byte it takes in.
`default_nettype none
module smf_cell (
    input  wire logic                          clk,
    input  wire logic                          shift,
    input  wire logic [smf_pkg::BYTE_W-1:0]    byte_in,
    input  wire logic [smf_pkg::BYTE_W-1:0]    pat_byte,
    input  wire logic                          used,
    output logic      [smf_pkg::BYTE_W-1:0]    byte_out,
    output logic                               agree
);

    logic [smf_pkg::BYTE_W-1:0] byte_reg;

    // byte_in is this slot's value after the shift
    assign agree    = !used || (byte_in == pat_byte);
    assign byte_out = byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule
`default_nettype wire

// ===== design/smf_outq.sv =====
// Small result queue: takes up to two results a beat, drains one a cycle while result_ready is high.
`default_nettype none
module smf_outq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire smf_pkg::smf_push_t   push,
    output logic                      room,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output smf_pkg::result_t          result
);

    smf_pkg::result_t                  q_reg [smf_pkg::Q_DEPTH];
    logic [smf_pkg::Q_PTR_W-1:0]       head_reg, head_next;
    logic [smf_pkg::Q_PTR_W-1:0]       tail_reg, tail_next;
    logic [smf_pkg::Q_CNT_W-1:0]       count_reg, count_next;
    logic                              pop;
    logic [smf_pkg::Q_PTR_W-1:0]       tail_plus;

    assign result_valid = (count_reg != '0);
    assign result       = q_reg[head_reg];
    assign pop          = result_valid && result_ready;
    assign room         = (count_reg <= smf_pkg::Q_CNT_W'(smf_pkg::Q_DEPTH - 2));
    assign tail_plus    = smf_pkg::Q_PTR_W'(tail_reg + 1'b1);

    always_comb
    begin
        head_next  = pop ? smf_pkg::Q_PTR_W'(head_reg + 1'b1) : head_reg;
        tail_next  = smf_pkg::Q_PTR_W'(tail_reg + push.cnt);
        count_next = smf_pkg::Q_CNT_W'(count_reg + smf_pkg::Q_CNT_W'(push.cnt)
                                       - smf_pkg::Q_CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            q_reg[tail_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            q_reg[tail_plus] <= push.second;
        end
    end

endmodule
`default_nettype wire
